[sv/blfd_pkg.sv]
`timescale 1ns / 1ps

package blfd_pkg;

   // Fixed field widths of the channel payloads.
   localparam int OP_W   = 2;
   localparam int DATA_W = 32;
   localparam int LEN_W  = 7;

   // Operation codes carried in the opcode field.
   typedef enum logic [OP_W-1:0] {
      OP_APPEND = 2'd0,
      OP_DELETE = 2'd1,
      OP_COUNT  = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   // Status codes of a result beat.
   localparam logic STAT_DONE = 1'b0;
   localparam logic STAT_FULL = 1'b1;

   // Broadcast from the controller to every cell of the chain.
   typedef struct packed {
      logic                     shift;    // every cell not being written takes its right neighbor
      logic                     put;      // the addressed cell takes put_data
      logic signed [DATA_W-1:0] put_data;
   } cell_ctrl_type;

endpackage

[sv/blfd_req_if.sv]
`timescale 1ns / 1ps

interface blfd_req_if import blfd_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [OP_W-1:0]          opcode;
   logic signed [DATA_W-1:0] item_value;
   logic signed [DATA_W-1:0] upper_bound;

   modport source (output valid, output opcode, output item_value, output upper_bound,
                   input ready);
   modport sink   (input valid, input opcode, input item_value, input upper_bound,
                   output ready);
endinterface

[sv/blfd_rsp_if.sv]
`timescale 1ns / 1ps

interface blfd_rsp_if import blfd_pkg::*; ();
   logic             valid;
   logic             ready;
   logic             status;
   logic [LEN_W-1:0] match_count;
   logic [LEN_W-1:0] list_length;

   modport source (output valid, output status, output match_count, output list_length,
                   input ready);
   modport sink   (input valid, input status, input match_count, input list_length,
                   output ready);
endinterface

[sv/bounded_list_with_filter_delete.sv]
`timescale 1ns / 1ps

// Ordered list of up to DEPTH signed 32-bit entries held in a chain of cells, one entry per
// cell, with cell 0 as the head. An append writes the new entry at the tail. On a delete or
// a range count the chain rotates one entry per cycle past the comparison logic at the head
// cell, dropping matches on a delete and tallying in-range entries on a count. A new beat is
// accepted once the previous item has moved into the result register, even while that result
// still waits. Entry contents are not cleared at reset; of the list state only the length
// resets to zero, and no entry at or beyond the length is ever observed. match_count and
// list_length carry the low 7 bits.
module bounded_list_with_filter_delete import blfd_pkg::*; #(
   parameter int DEPTH = 64
) (
   input  logic       clock,
   input  logic       reset,
   blfd_req_if.sink   req_bus,
   blfd_rsp_if.source rsp_bus
);

   localparam int IW = $clog2(DEPTH);

   cell_ctrl_type            cell_ctrl;
   logic [IW-1:0]            put_idx;
   logic signed [DATA_W-1:0] cell_data [DEPTH];

   // Sequencer and result register.
   blfd_ctrl #(
      .DEPTH (DEPTH)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req       (req_bus),
      .rsp       (rsp_bus),
      .head_data (cell_data[0]),
      .cell_ctrl (cell_ctrl),
      .put_idx   (put_idx)
   );

   // Cell chain; the last cell closes the ring back to the head.
   for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
      blfd_cell #(
         .IW  (IW),
         .IDX (gi)
      ) u_cell (
         .clock      (clock),
         .ctrl       (cell_ctrl),
         .put_idx    (put_idx),
         .right_data (cell_data[(gi + 1) % DEPTH]),
         .data       (cell_data[gi])
      );
   end

endmodule

[sv/blfd_cell.sv]
`timescale 1ns / 1ps

module blfd_cell import blfd_pkg::*; #(
   parameter int IW  = 6,
   parameter int IDX = 0
) (
   input  logic                     clock,
   input  cell_ctrl_type            ctrl,
   input  logic [IW-1:0]            put_idx,
   input  logic signed [DATA_W-1:0] right_data,
   output logic signed [DATA_W-1:0] data
);

   logic signed [DATA_W-1:0] data_ff;
   logic signed [DATA_W-1:0] data_in;
   logic                     addressed;

   assign addressed = (put_idx == IW'(IDX));

   // A targeted write wins; otherwise the cell shifts or holds.
   always_comb begin
      data_in = data_ff;
      if (ctrl.put && addressed) begin
         data_in = ctrl.put_data;
      end else if (ctrl.shift) begin
         data_in = right_data;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

[sv/blfd_ctrl.sv]
`timescale 1ns / 1ps

module blfd_ctrl import blfd_pkg::*; #(
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     reset,
   blfd_req_if.sink                 req,
   blfd_rsp_if.source               rsp,
   input  logic signed [DATA_W-1:0] head_data,
   output cell_ctrl_type            cell_ctrl,
   output logic [$clog2(DEPTH)-1:0] put_idx
);

   localparam int CW = $clog2(DEPTH + 1);
   localparam int IW = $clog2(DEPTH);

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_EXEC   = 3'b010,
      ST_FINISH = 3'b100
   } state_type;

   state_type                state_ff, state_in;
   op_type                   op_ff, op_in;
   logic signed [DATA_W-1:0] val_ff, val_in;
   logic signed [DATA_W-1:0] hi_ff, hi_in;
   logic [CW-1:0]            cnt_ff, cnt_in;
   logic [CW-1:0]            steps_ff, steps_in;
   logic [CW-1:0]            matches_ff, matches_in;
   logic                     status_ff, status_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     rsp_status_ff, rsp_status_in;
   logic [LEN_W-1:0]         rsp_match_ff, rsp_match_in;
   logic [LEN_W-1:0]         rsp_len_ff, rsp_len_in;

   logic                     accept;
   logic                     keep;
   logic                     in_range;
   logic                     load_rsp;

   assign accept   = req.valid && req.ready;
   assign req.ready = (state_ff == ST_IDLE);
   assign load_rsp = (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp.ready);

   // Head cell tests: a delete drops equal entries, a count keeps all of them.
   assign in_range = (head_data >= val_ff) && (head_data <= hi_ff);
   assign keep     = (op_ff == OP_DELETE) ? (head_data != val_ff) : 1'b1;

   // Sequencer: one rotation step per cycle while entries remain unvisited.
   always_comb begin
      state_in   = state_ff;
      op_in      = op_ff;
      val_in     = val_ff;
      hi_in      = hi_ff;
      cnt_in     = cnt_ff;
      steps_in   = steps_ff;
      matches_in = matches_ff;
      status_in  = status_ff;
      cell_ctrl  = '{shift: 1'b0, put: 1'b0, put_data: val_ff};
      put_idx    = cnt_ff[IW-1:0];

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               op_in      = op_type'(req.opcode);
               val_in     = req.item_value;
               hi_in      = req.upper_bound;
               steps_in   = cnt_ff;
               matches_in = '0;
               status_in  = STAT_DONE;
               state_in   = ST_EXEC;
            end
         end
         ST_EXEC: begin
            unique case (op_ff) inside
               OP_APPEND: begin
                  if (cnt_ff == CW'(DEPTH)) begin
                     status_in = STAT_FULL;
                  end else begin
                     cell_ctrl.put = 1'b1;
                     cnt_in        = cnt_ff + 1'b1;
                  end
                  state_in = ST_FINISH;
               end
               OP_DELETE, OP_COUNT: begin
                  if (steps_ff == '0) begin
                     state_in = ST_FINISH;
                  end else begin
                     // Pop the head; a kept entry goes back in at the tail.
                     cell_ctrl.shift    = 1'b1;
                     cell_ctrl.put      = keep;
                     cell_ctrl.put_data = head_data;
                     put_idx            = IW'(cnt_ff - 1'b1);
                     steps_in           = steps_ff - 1'b1;
                     if (!keep) begin
                        cnt_in = cnt_ff - 1'b1;
                     end
                     if (op_ff == OP_COUNT && in_range) begin
                        matches_in = matches_ff + 1'b1;
                     end
                  end
               end
               default: begin
                  state_in = ST_FINISH;
               end
            endcase
         end
         ST_FINISH: begin
            if (load_rsp) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Result register decouples the finished item from the next one.
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_match_in  = rsp_match_ff;
      rsp_len_in    = rsp_len_ff;
      if (load_rsp) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = status_ff;
         rsp_match_in  = LEN_W'(matches_ff);
         rsp_len_in    = LEN_W'(cnt_ff);
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      val_ff        <= val_in;
      hi_ff         <= hi_in;
      steps_ff      <= steps_in;
      matches_ff    <= matches_in;
      status_ff     <= status_in;
      rsp_status_ff <= rsp_status_in;
      rsp_match_ff  <= rsp_match_in;
      rsp_len_ff    <= rsp_len_in;
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.status      = rsp_status_ff;
   assign rsp.match_count = rsp_match_ff;
   assign rsp.list_length = rsp_len_ff;

   // The list never holds more than DEPTH entries.
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(DEPTH))
      else $error("entry count above depth");

   // Unvisited entries are always a subset of the queue being rotated.
   a_steps_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EXEC) |-> (steps_ff <= cnt_ff))
      else $error("walk step count exceeds queue size");

   // A refused append leaves the length untouched.
   a_full_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EXEC && op_ff == OP_APPEND && cnt_ff == CW'(DEPTH))
      |=> $stable(cnt_ff))
      else $error("refused append changed the length");

   // A range count rotates the list without changing its length.
   a_count_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EXEC && op_ff == OP_COUNT) |=> $stable(cnt_ff))
      else $error("range count changed the length");

endmodule
